### rtl/gdr_pkg.sv
// Package: payload types, constants and command/status types of the grid ray caster.
`default_nettype none
package gdr_pkg;

    localparam int unsigned DEPTH_RESET = 20;
    localparam int unsigned DIST_W = 41;
    localparam logic [DIST_W-1:0] STEP_SAT = 41'h0FF_FFFF_FFFF;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    typedef struct packed {
        logic               action;
        logic [3:0]         cell_x;
        logic [3:0]         cell_y;
        logic [2:0]         cell_value;
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
    } t_in_item;

    typedef struct packed {
        logic        wall_hit;
        logic [2:0]  wall_kind;
        logic        hit_side;
        logic [15:0] perp_distance;
        logic [11:0] wall_fraction;
        logic [3:0]  hit_cell_x;
        logic [3:0]  hit_cell_y;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic write_cell;
        logic div_start;
        logic init_side;
        logic step;
        logic check;
        logic frac_mul;
        logic finish_hit;
        logic finish_miss;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic stop_miss;
        logic stop_hit;
    } t_status;

endpackage
`default_nettype wire

### rtl/gdr_ctrl.sv
// Controller state machine sequencing writes and ray walks.
`default_nettype none
module gdr_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire                  i_action,
    input  wire gdr_pkg::t_status i_status,
    output gdr_pkg::t_cmd        o_cmd,
    input  wire                  i_out_busy
);
    import gdr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_STEP = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_FRAC = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;
    localparam logic [2:0] S_MISS = 3'd7;

    logic [2:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ACT_CAST) begin
                        o_cmd.load = 1'b1;
                        o_cmd.div_start = 1'b1;
                        n_state = S_DIV;
                    end else begin
                        o_cmd.write_cell = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init_side = 1'b1;
                n_state = S_STEP;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.check = 1'b1;
                if (i_status.stop_miss) begin
                    n_state = S_MISS;
                end else if (i_status.stop_hit) begin
                    n_state = S_FRAC;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_FRAC: begin
                o_cmd.frac_mul = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_out_busy) begin
                    o_cmd.finish_hit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MISS: begin
                if (!i_out_busy) begin
                    o_cmd.finish_miss = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_finish_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.finish_hit && o_cmd.finish_miss))
        else $error("both finish commands");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE)
        else $error("load outside idle");
    a_step_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |=> o_cmd.check)
        else $error("step not followed by check");
`endif
endmodule
`default_nettype wire

### rtl/gdr_datapath.sv
// Datapath: map memory, reciprocal divider, DDA walk and hit fraction.
`default_nettype none
module gdr_datapath #(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire gdr_pkg::t_in_item i_item,
    input  wire gdr_pkg::t_cmd    i_cmd,
    input  wire [5:0]             i_depth_lim,
    output gdr_pkg::t_status      o_status,
    output gdr_pkg::t_out_item    o_result
);
    import gdr_pkg::*;

    localparam int XW = $clog2(GRID_WIDTH);
    localparam int YW = $clog2(GRID_HEIGHT);
    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = 18;

    logic [2:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [2:0] r_rd;
    logic r_rd_vld;

    logic [15:0] r_px, r_py;
    logic signed [15:0] r_dx, r_dy;
    logic signed [CW-1:0] r_mx, r_my;
    logic [DIST_W-1:0] r_ddx, r_ddy, r_sdx, r_sdy, r_dist;
    logic r_side;

    // radix-2 restoring divider for both axes in parallel
    logic [5:0] r_cnt;
    logic r_busy;
    logic [30:0] r_qx, r_qy;
    logic [16:0] r_rx, r_ry;
    logic [15:0] mag_x, mag_y;
    logic [17:0] tx, ty;
    logic [30:0] dividend;

    assign mag_x = r_dx[15] ? 16'(-r_dx) : r_dx;
    assign mag_y = r_dy[15] ? 16'(-r_dy) : r_dy;
    assign dividend = 31'h4000_0000;
    assign tx = {r_rx, dividend[5'(r_cnt)]};
    assign ty = {r_ry, dividend[5'(r_cnt)]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == 6'd0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_cnt <= 6'd30;
            r_rx <= '0;
            r_ry <= '0;
            r_qx <= '0;
            r_qy <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (tx >= {2'b0, mag_x}) begin
                r_rx <= 17'(tx - {2'b0, mag_x});
                r_qx <= {r_qx[29:0], 1'b1};
            end else begin
                r_rx <= tx[16:0];
                r_qx <= {r_qx[29:0], 1'b0};
            end
            if (ty >= {2'b0, mag_y}) begin
                r_ry <= 17'(ty - {2'b0, mag_y});
                r_qy <= {r_qy[29:0], 1'b1};
            end else begin
                r_ry <= ty[16:0];
                r_qy <= {r_qy[29:0], 1'b0};
            end
        end
    end

    assign o_status.div_done = r_busy && r_cnt == 6'd0;

    // side distance init multiplications
    logic [11:0] fx, fy;
    logic [12:0] ffx, ffy;
    logic [DIST_W-1:0] dx_step, dy_step;
    logic [43:0] prod_x, prod_y;

    assign fx = r_px[11:0];
    assign fy = r_py[11:0];
    assign ffx = r_dx[15] ? {1'b0, fx} : 13'(13'd4096 - {1'b0, fx});
    assign ffy = r_dy[15] ? {1'b0, fy} : 13'(13'd4096 - {1'b0, fy});
    assign dx_step = (mag_x == 16'd0) ? STEP_SAT : DIST_W'(r_qx);
    assign dy_step = (mag_y == 16'd0) ? STEP_SAT : DIST_W'(r_qy);
    assign prod_x = 44'(ffx) * 44'(r_qx);
    assign prod_y = 44'(ffy) * 44'(r_qy);

    // walk
    logic take_x;
    logic [DIST_W-1:0] limit;
    logic out_x, out_y;
    logic [AW-1:0] rd_addr, wr_addr;
    logic signed [CW-1:0] nmx, nmy;

    assign take_x = r_sdx < r_sdy;
    assign nmx = take_x ? (r_dx[15] ? r_mx - CW'(1) : r_mx + CW'(1)) : r_mx;
    assign nmy = take_x ? r_my : (r_dy[15] ? r_my - CW'(1) : r_my + CW'(1));
    assign limit = DIST_W'({i_depth_lim, 16'd0});
    assign out_x = r_mx < 0 || r_mx >= CW'(GRID_WIDTH);
    assign out_y = r_my < 0 || r_my >= CW'(GRID_HEIGHT);
    assign rd_addr = AW'(nmy[YW-1:0]) * AW'(GRID_WIDTH) + AW'(nmx[XW-1:0]);
    assign wr_addr = AW'(i_item.cell_y[YW-1:0]) * AW'(GRID_WIDTH)
                   + AW'(i_item.cell_x[XW-1:0]);

    logic [2:0] cell_now;
    assign cell_now = r_rd_vld ? r_rd : 3'd0;

    assign o_status.stop_miss = (r_dist >= limit) || out_x || out_y;
    assign o_status.stop_hit  = cell_now != 3'd0;

    logic wr_ok;
    assign wr_ok = 32'(i_item.cell_x) < GRID_WIDTH && 32'(i_item.cell_y) < GRID_HEIGHT;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_cell && wr_ok) begin
            r_mem[wr_addr] <= i_item.cell_value;
        end
        if (i_cmd.step) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.step) begin
                r_rd_vld <= r_valid[rd_addr];
            end
            if (i_cmd.write_cell && wr_ok) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // fraction
    logic [47:0] r_frac_prod;
    logic [47:0] base;
    logic [47:0] wsum;
    logic signed [15:0] dsel;
    assign dsel = r_side ? r_dx : r_dy;
    assign base = r_side ? {14'd0, r_px, 18'd0} : {14'd0, r_py, 18'd0};
    assign wsum = base + r_frac_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_item.pos_x;
            r_py <= i_item.pos_y;
            r_dx <= i_item.dir_x;
            r_dy <= i_item.dir_y;
            r_mx <= CW'(i_item.pos_x[15:12]);
            r_my <= CW'(i_item.pos_y[15:12]);
        end
        if (i_cmd.init_side) begin
            r_ddx <= dx_step;
            r_ddy <= dy_step;
            r_sdx <= (mag_x == 16'd0) ? STEP_SAT : DIST_W'(prod_x[43:12]);
            r_sdy <= (mag_y == 16'd0) ? STEP_SAT : DIST_W'(prod_y[43:12]);
        end
        if (i_cmd.step) begin
            r_mx <= nmx;
            r_my <= nmy;
            r_side <= !take_x;
            if (take_x) begin
                r_dist <= r_sdx;
                r_sdx <= r_sdx + r_ddx;
            end else begin
                r_dist <= r_sdy;
                r_sdy <= r_sdy + r_ddy;
            end
        end
        if (i_cmd.frac_mul) begin
            r_frac_prod <= 48'($signed({1'b0, r_dist[29:0]}) * dsel);
        end
        if (i_cmd.finish_hit) begin
            o_result.wall_hit <= 1'b1;
            o_result.wall_kind <= 3'(r_rd - 3'd1);
            o_result.hit_side <= r_side;
            o_result.perp_distance <= r_dist[21:6];
            o_result.wall_fraction <= wsum[29:18];
            o_result.hit_cell_x <= 4'(r_mx);
            o_result.hit_cell_y <= 4'(r_my);
        end
        if (i_cmd.finish_miss) begin
            o_result <= '0;
        end
    end

`ifndef NO_ASSERTIONS
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> r_busy)
        else $error("divider did not start");
    a_side_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_side ? $stable(r_mx) : $stable(r_my)))
        else $error("both axes moved");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_cmd.load)
        else $error("load during divide");
`endif
endmodule
`default_nettype wire

### rtl/grid_dda_ray_caster_core.sv
// Top level of the grid DDA ray caster: handshakes, register and output stage.
// Use: input beats carry an action. A write beat stores one map cell. A cast
// beat walks a ray through the map and yields one result beat.
// Steps of a cast: the accept cycle, the divider (two reciprocals run side by
// side, one quotient bit a cycle), init, then a step and a check per grid step
// (one map read per step), a fraction multiply on a hit and the output cycle;
// the result beat is valid the cycle after. One item is in flight at a time;
// the next is taken after the result is loaded into the output register. The
// depth limit register is to be written on the config channel only while idle;
// the block itself does not enforce this. Reset loads 20 and clears the map.
// When the receiver stalls, the result holds in the output register and the
// next ray may still be walked; its result waits until the register empties.
// Reset is synchronous, active low; no output beat is valid after reset.
`default_nettype none
module grid_dda_ray_caster_core #(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire gdr_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output gdr_pkg::t_out_item     o_out_data,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire [5:0]              i_cfg_data
);
    import gdr_pkg::*;

    t_cmd cmd;
    t_status status;
    t_out_item result;
    logic [5:0] r_depth_lim;
    t_in_item r_item;
    logic out_busy;

    assign o_cfg_ready = 1'b1;
    assign out_busy = o_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_lim <= 6'(DEPTH_RESET);
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_depth_lim <= i_cfg_data;
            end
            if (cmd.finish_hit || cmd.finish_miss) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.load) begin
            r_item <= i_in_data;
        end
    end

    t_in_item dp_item;
    assign dp_item = cmd.load || cmd.write_cell ? i_in_data : r_item;

    gdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_in_data.action),
        .i_status   (status),
        .o_cmd      (cmd),
        .i_out_busy (out_busy)
    );

    gdr_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (dp_item),
        .i_cmd       (cmd),
        .i_depth_lim (r_depth_lim),
        .o_status    (status),
        .o_result    (result)
    );

    assign o_out_data = result;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output dropped while stalled");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.finish_hit || cmd.finish_miss) |-> !out_busy)
        else $error("result overwrote pending beat");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.wall_hit |-> o_out_data.perp_distance == 16'd0)
        else $error("miss with nonzero distance");
`endif
endmodule
`default_nettype wire

### test/tb_top.sv
// Testbench for the grid ray caster: random maps and rays checked against a DDA predictor.
module tb_top;
    import gdr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 150;

    class ray_scoreboard;
        logic [2:0] cells [256];
        logic [5:0] depth_lim;
        t_out_item  pending [$];
        int         errors;

        function new();
            foreach (cells[k]) cells[k] = '0;
            depth_lim = 6'(DEPTH_RESET);
            errors = 0;
        endfunction

        function logic [63:0] recip(int d);
            int mag;
            mag = (d < 0) ? -d : d;
            if (mag == 0) return 64'(STEP_SAT);
            return (64'd1 << 30) / 64'(mag);
        endfunction

        function t_out_item trace_ray(t_in_item it);
            t_out_item r;
            int dxs, dys, mx, my, sx, sy;
            logic [63:0] ddx, ddy, sdx, sdy, hit_d, limit, fx, fy, base, prod, w;
            longint sd;
            logic side;
            logic [2:0] c;
            r = '0;
            dxs = int'(it.dir_x);
            dys = int'(it.dir_y);
            mx = int'(it.pos_x[15:12]);
            my = int'(it.pos_y[15:12]);
            fx = 64'(it.pos_x[11:0]);
            fy = 64'(it.pos_y[11:0]);
            ddx = recip(dxs);
            ddy = recip(dys);
            limit = 64'(depth_lim) << 16;
            if (dxs < 0) begin
                sx = -1; sdx = (fx * ddx) >> 12;
            end else begin
                sx = 1;  sdx = ((64'd4096 - fx) * ddx) >> 12;
            end
            if (dys < 0) begin
                sy = -1; sdy = (fy * ddy) >> 12;
            end else begin
                sy = 1;  sdy = ((64'd4096 - fy) * ddy) >> 12;
            end
            while (1) begin
                if (sdx < sdy) begin
                    hit_d = sdx; sdx += ddx; mx += sx; side = 1'b0;
                end else begin
                    hit_d = sdy; sdy += ddy; my += sy; side = 1'b1;
                end
                if (hit_d >= limit) return r;
                if (mx < 0 || mx > 15 || my < 0 || my > 15) return r;
                c = cells[my * 16 + mx];
                if (c != 0) begin
                    if (side == 1'b0) begin
                        base = 64'(it.pos_y) << 18; sd = longint'(dys);
                    end else begin
                        base = 64'(it.pos_x) << 18; sd = longint'(dxs);
                    end
                    prod = hit_d * 64'(sd);
                    w = (base + prod) >> 18;
                    r.wall_hit = 1'b1;
                    r.wall_kind = c - 3'd1;
                    r.hit_side = side;
                    r.perp_distance = hit_d[21:6];
                    r.wall_fraction = w[11:0];
                    r.hit_cell_x = mx[3:0];
                    r.hit_cell_y = my[3:0];
                    return r;
                end
            end
            return r;
        endfunction

        function void note_input(t_in_item it);
            if (it.action == ACT_CAST) pending.push_back(trace_ray(it));
            else cells[{it.cell_y, it.cell_x}] = it.cell_value;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task cmp(string name, int got, int want);
            if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            want = pending.pop_front();
            cmp("wall_hit", int'(got.wall_hit), int'(want.wall_hit));
            cmp("wall_kind", int'(got.wall_kind), int'(want.wall_kind));
            cmp("hit_side", int'(got.hit_side), int'(want.hit_side));
            cmp("perp_distance", int'(got.perp_distance), int'(want.perp_distance));
            cmp("wall_fraction", int'(got.wall_fraction), int'(want.wall_fraction));
            cmp("hit_cell_x", int'(got.hit_cell_x), int'(want.hit_cell_x));
            cmp("hit_cell_y", int'(got.hit_cell_y), int'(want.hit_cell_y));
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_data = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [5:0] cfg_data = '0;
    wire        o_in_ready, o_out_valid, o_cfg_ready;
    t_out_item  o_out_data;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;
    ray_scoreboard sb = new();

    grid_dda_ray_caster_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready), .i_in_data(in_data),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) sb.check_result(o_out_data);
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task send(t_in_item it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
    endtask

    task drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task set_depth(logic [5:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.depth_lim = v;
        cfg_valid <= 1'b0;
    endtask

    function t_in_item wr_item(int x, int y, int v);
        t_in_item it;
        it = '0;
        it.action = ACT_WRITE;
        it.cell_x = 4'(x); it.cell_y = 4'(y); it.cell_value = 3'(v);
        it.pos_x = 16'($urandom); it.pos_y = 16'($urandom);
        return it;
    endfunction

    function t_in_item cast_item(int px, int py, int dx, int dy);
        t_in_item it;
        it = '0;
        it.action = ACT_CAST;
        it.cell_x = 4'($urandom); it.cell_y = 4'($urandom);
        it.cell_value = 3'($urandom);
        it.pos_x = 16'(px); it.pos_y = 16'(py);
        it.dir_x = 16'(dx); it.dir_y = 16'(dy);
        return it;
    endfunction

    function int rand_dir();
        int r;
        r = $urandom_range(99);
        if (r < 6) return 0;
        if (r < 10) return ($urandom_range(1)) ? 16384 : -16384;
        return $urandom_range(32768) - 16384;
    endfunction

    function t_in_item rand_item();
        if ($urandom_range(99) < 20)
            return wr_item($urandom_range(15), $urandom_range(15),
                           ($urandom_range(99) < 35) ? $urandom_range(7, 1) : 0);
        return cast_item($urandom_range(65535), $urandom_range(65535),
                         rand_dir(), rand_dir());
    endfunction

    task run_phase(int n, int mode, int pause_at);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
        endcase
        for (int k = 0; k < n; k++) begin
            if (k == pause_at) drain();
            send(rand_item());
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(cast_item(16'h8800, 16'h8800, 16384, 0));
        send(wr_item(12, 8, 3));
        send(wr_item(0, 0, 7));
        send(wr_item(15, 15, 1));
        send(wr_item(8, 8, 2));
        send(cast_item(16'h8800, 16'h8800, 16384, 0));
        send(cast_item(16'h8800, 16'h8800, -16384, 0));
        send(cast_item(16'h8800, 16'h8800, 0, 0));
        send(cast_item(16'h8800, 16'h8800, 0, -16384));
        send(cast_item(16'h0800, 16'h0800, 11585, 11585));
        send(cast_item(16'h2000, 16'h2000, -11585, -11585));
        send(cast_item(16'hFFFF, 16'hFFFF, 16384, 16384));
        send(cast_item(16'h0000, 16'h0000, -16384, -16384));
        send(cast_item(16'hE800, 16'h1000, 11585, 11585));
        send(cast_item(16'h1000, 16'h1000, -1, -1));
        send(cast_item(16'hF000, 16'hF000, 1, 16384));
        send(wr_item(8, 8, 0));
        send(wr_item(12, 8, 0));
        send(cast_item(16'h8800, 16'h8800, 16384, -9000));
        drain();

        set_depth(6'd63);
        run_phase(110, 0, -1);
        set_depth(6'd1);
        run_phase(100, 1, -1);
        set_depth(6'd5);
        run_phase(110, 2, 50);
        set_depth(6'd63);
        run_phase(110, 3, -1);
        set_depth(6'($urandom_range(63, 1)));
        run_phase(110, 1, -1);
        set_depth(6'd20);
        run_phase(110, 2, -1);
        set_depth(6'($urandom_range(63, 1)));
        run_phase(100, 3, -1);
        set_depth(6'd40);
        run_phase(100, 0, -1);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/gdr_pkg.sv
rtl/gdr_ctrl.sv
rtl/gdr_datapath.sv
rtl/grid_dda_ray_caster_core.sv
test/tb_top.sv
